// ===== rtl/weighted_index_sampler_assert.svh =====
// Assertion macros for the weighted index sampler.
`ifndef WEIGHTED_INDEX_SAMPLER_ASSERT_SVH
`define WEIGHTED_INDEX_SAMPLER_ASSERT_SVH

// Checks that a consequence holds in the same cycle as its cause.
`define WIS_ASSERT_SAME(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define WIS_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== rtl/wis_pkg.sv =====
// Package with the sizes, codes and control types of the weighted index sampler.
package wis_pkg;

  // Table geometry and arithmetic widths.
  localparam int MAX_ENTRIES = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int SUM_W       = 24;
  localparam int VAL_W       = 33;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int V_LO_W      = 17;
  localparam int V_HI_W      = VAL_W - V_LO_W;
  localparam int P_LO_W      = V_LO_W + SUM_W;
  localparam int P_HI_W      = V_HI_W + SUM_W;
  localparam int RHS_W       = VAL_W + SUM_W;
  localparam int FRAC_W      = 32;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DRAW   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOPOS = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Kinds of result word the controller asks for.
  localparam logic [2:0] RES_ZERO   = 3'd0;
  localparam logic [2:0] RES_APPEND = 3'd1;
  localparam logic [2:0] RES_FULL   = 3'd2;
  localparam logic [2:0] RES_NOPOS  = 3'd3;
  localparam logic [2:0] RES_DRAW   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       clear;
    logic       append;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_sum;
    logic       search_init;
    logic       probe;
    logic       finish;
    logic [2:0] res_kind;
  } wis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       value_zero;
    logic       search_done;
  } wis_stat_t;

endpackage

// ===== rtl/wis_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module wis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wis_ctrl.sv =====
// Controller state machine of the weighted index sampler.
module wis_ctrl
  import wis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  wis_stat_t stat,
  output logic      busy,
  output wis_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_MUL_HI  = 3'd2;
  localparam logic [2:0] S_MUL_SUM = 3'd3;
  localparam logic [2:0] S_SEARCH  = 3'd4;
  localparam logic [2:0] S_COMPARE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_kind = RES_ZERO;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.finish   = 1'b1;
            cmd.res_kind = RES_ZERO;
            state_next   = S_IDLE;
          end
          OP_APPEND: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              cmd.res_kind = RES_FULL;
            end else begin
              cmd.append   = 1'b1;
              cmd.res_kind = RES_APPEND;
            end
          end
          OP_DRAW: begin
            if (stat.empty) begin
              cmd.finish   = 1'b1;
              cmd.res_kind = RES_NOPOS;
              state_next   = S_IDLE;
            end else if (stat.value_zero) begin
              cmd.finish   = 1'b1;
              cmd.res_kind = RES_ZERO;
              state_next   = S_IDLE;
            end else begin
              cmd.mul_lo = 1'b1;
              state_next = S_MUL_HI;
            end
          end
          OP_NONE: begin
            cmd.finish   = 1'b1;
            cmd.res_kind = RES_ZERO;
            state_next   = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        cmd.mul_sum     = 1'b1;
        cmd.search_init = 1'b1;
        state_next      = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.finish   = 1'b1;
          cmd.res_kind = RES_DRAW;
          state_next   = S_IDLE;
        end else begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.probe  = 1'b1;
        state_next = S_SEARCH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wis_datapath.sv =====
// Datapath of the weighted index sampler: running sum table, product and search.
module wis_datapath
  import wis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             op,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [VAL_W-1:0]       draw_value,
  input  wis_cmd_t               cmd,
  output wis_stat_t              stat,
  output logic                   done,
  output logic [IDX_W-1:0]       index,
  output logic [1:0]             status
);

  logic [1:0]             op_r;
  logic [WEIGHT_BITS-1:0] weight_r;
  logic [VAL_W-1:0]       value_r;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       total;
  logic [P_LO_W-1:0]      p_lo;
  logic [P_HI_W-1:0]      p_hi;
  logic [RHS_W-1:0]       rhs;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;

  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_sat;
  logic [CNT_W-1:0]       mid;
  logic [SUM_W-1:0]       rd_sum;
  logic [RHS_W-1:0]       lhs;
  logic                   reaches;
  logic [CNT_W-1:0]       draw_pick;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      weight_r <= weight;
      value_r  <= draw_value;
    end
  end

  // New running sum, saturated at the top of the sum range.
  always_comb begin
    sum_ext = {1'b0, total} + {{(SUM_W + 1 - WEIGHT_BITS){1'b0}}, weight_r};
    sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  end

  // Entry count and total.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      total <= '0;
    end else if (cmd.append) begin
      count <= count + 1'b1;
      total <= sum_sat;
    end
  end

  // Probe point of the search; lo and hi hold between search and compare.
  assign mid = lo + ((hi - lo) >> 1);

  wis_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[IDX_W-1:0]),
    .wdata (sum_sat),
    .raddr (mid[IDX_W-1:0]),
    .rdata (rd_sum)
  );

  // Product of draw value and total in two partial products.
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      p_lo <= P_LO_W'(value_r[V_LO_W-1:0]) * P_LO_W'(total);
    end
    if (cmd.mul_hi) begin
      p_hi <= P_HI_W'(value_r[VAL_W-1:V_LO_W]) * P_HI_W'(total);
    end
    if (cmd.mul_sum) begin
      rhs <= {{(RHS_W - P_LO_W){1'b0}}, p_lo} + {p_hi, {V_LO_W{1'b0}}};
    end
  end

  // Exact test of sum / total >= value / 2^32 (value has 32 fraction bits).
  always_comb begin
    lhs     = {{(RHS_W - SUM_W - FRAC_W){1'b0}}, rd_sum, {FRAC_W{1'b0}}};
    reaches = (lhs >= rhs);
  end

  // Binary search bounds.
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.probe) begin
      if (reaches) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
  end

  // A value above every sum lands on the last entry.
  assign draw_pick = (lo == count) ? (count - 1'b1) : lo;

  // Result word and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.res_kind)
        RES_APPEND: begin
          index  <= count[IDX_W-1:0];
          status <= STAT_OK;
        end
        RES_FULL: begin
          index  <= '0;
          status <= STAT_FULL;
        end
        RES_NOPOS: begin
          index  <= '0;
          status <= STAT_NOPOS;
        end
        RES_DRAW: begin
          index  <= draw_pick[IDX_W-1:0];
          status <= STAT_OK;
        end
        default: begin
          index  <= '0;
          status <= STAT_OK;
        end
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op          = op_r;
    stat.full        = (count >= CNT_W'(MAX_ENTRIES));
    stat.empty       = (count == '0) || (total == '0);
    stat.value_zero  = (value_r == '0);
    stat.search_done = (lo >= hi);
  end

endmodule

// ===== rtl/weighted_index_sampler.sv =====
// Weighted index sampler top level: controller, datapath and assertions.
//
// A word is accepted on a rising edge with start high and busy low; the result
// word shows on index and status for one cycle with done high and must be taken
// then, as the receiver cannot stall. Clear, append, the unused op code and the
// early draw cases (no positive weight, zero value) strobe done from the decode
// state through the done register. A draw that searches first forms the
// value-times-total product from two partial products and their sum, then runs
// a binary search of at most ceil(log2(n + 1)) probes for n stored entries;
// each probe of the single-read-port sum table issues the registered read in
// the search state and compares in the compare state. busy drops in the cycle
// that done is shown, so the next word may be accepted then. The table content
// is not cleared at reset; the entry count and total are.
`include "weighted_index_sampler_assert.svh"

module weighted_index_sampler
  import wis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [VAL_W-1:0]       draw_value,
  output logic                   done,
  output logic [IDX_W-1:0]       index,
  output logic [1:0]             status
);

  wis_cmd_t  cmd;
  wis_stat_t stat;

  wis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  wis_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .weight     (weight),
    .draw_value (draw_value),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .index      (index),
    .status     (status)
  );

  // An accepted word keeps the block busy in the next cycle.
  `WIS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  // One strobe per word: strobes never come back to back.
  `WIS_ASSERT_NEXT(a_done_single, done, !done, "result strobe repeated")
  // The block is free again when a result is shown.
  `WIS_ASSERT_SAME(a_done_idle, done, !busy, "busy while result shown")
  // Error results carry entry zero.
  `WIS_ASSERT_SAME(a_err_index, done && (status != STAT_OK), index == '0,
                   "error result with nonzero index")

endmodule
